// File: sv/pfla_pkg.sv
// Package for the page free list allocator: widths, codes, controller states
// and the command/status structs between controller and datapath.
// No dependencies.
package pfla_pkg;

   localparam int PAGE_BITS_DEFAULT = 16;
   localparam int PAGE_W            = 16;
   localparam int STATUS_W          = 2;
   localparam int COUNT_W           = 17;
   localparam int MARK_W            = 2;

   localparam logic CMD_FREE  = 1'b0;
   localparam logic CMD_ALLOC = 1'b1;

   localparam logic [STATUS_W-1:0] RSP_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] RSP_EMPTY  = 2'd1;
   localparam logic [STATUS_W-1:0] RSP_REJECT = 2'd2;

   localparam int MARK_FREE_BIT = 1;
   localparam logic [MARK_W-1:0] MARK_NONE      = 2'b00;
   localparam logic [MARK_W-1:0] MARK_ALLOCATED = 2'b01;
   localparam logic [MARK_W-1:0] MARK_POOLED    = 2'b10;

   typedef enum logic [1:0] {
      CLEAR,
      IDLE,
      EXEC
   } state_type;

   typedef struct packed {
      logic clear;
      logic load;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic slot_free;
   } dp_status_type;

endpackage

// File: sv/pfla_if.sv
// Handshake channels for the request and response words.
// Depends on pfla_pkg for payload widths.
interface pfla_req_if;
   logic                        valid;
   logic                        ready;
   logic                        cmd;
   logic [pfla_pkg::PAGE_W-1:0] page_number;

   modport source (output valid, cmd, page_number, input ready);
   modport sink   (input valid, cmd, page_number, output ready);
endinterface

interface pfla_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [pfla_pkg::PAGE_W-1:0]   alloc_page;
   logic [pfla_pkg::STATUS_W-1:0] status;
   logic [pfla_pkg::COUNT_W-1:0]  free_count;

   modport source (output valid, alloc_page, status, free_count, input ready);
   modport sink   (input valid, alloc_page, status, free_count, output ready);
endinterface

// File: sv/page_free_list_allocator.sv
// Page free list allocator: FIFO pool of free pages with per-page marks.
// An accepted request word loads the request registers and memory reads; its response
// word is registered at commit once the response slot is free. One request is in flight.
// The response register lets the next request in while a response waits.
// Reset: pointers and count clear, then a sweep over all 2**PAGE_NUMBER_BITS addresses
// (65536 by default) clears the marks memory with req_chan.ready held low.
module page_free_list_allocator #(
   parameter int PAGE_NUMBER_BITS = pfla_pkg::PAGE_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   pfla_req_if.sink   req_chan,
   pfla_rsp_if.source rsp_chan
);
   import pfla_pkg::*;

   ctrl_cmd_type  ctrl_cmd;
   dp_status_type dp_sts;

   pfla_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (dp_sts),
      .cmd       (ctrl_cmd)
   );

   pfla_dp #(.PAGE_NUMBER_BITS(PAGE_NUMBER_BITS)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (ctrl_cmd),
      .sts             (dp_sts),
      .req_cmd         (req_chan.cmd),
      .req_page_number (req_chan.page_number),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_alloc_page  (rsp_chan.alloc_page),
      .rsp_status      (rsp_chan.status),
      .rsp_free_count  (rsp_chan.free_count)
   );

   a_no_req_during_clear: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.clear |-> !req_chan.ready)
      else $error("request taken during marks sweep");

   a_commit_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.commit |-> dp_sts.slot_free)
      else $error("response overwritten before taken");

   a_one_request_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("second request accepted while one is in flight");

   a_empty_answer: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.status == RSP_EMPTY)
      |-> (rsp_chan.free_count == '0 && rsp_chan.alloc_page == '0))
      else $error("empty pool answer with nonzero page or count");

endmodule

// File: sv/pfla_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module pfla_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/pfla_ctrl.sv
// Controller: sequences the marks clearing sweep, request load and commit.
// Depends on pfla_pkg.
module pfla_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  pfla_pkg::dp_status_type sts,
   output pfla_pkg::ctrl_cmd_type  cmd
);
   import pfla_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CLEAR: begin
            if (sts.clear_last) state_in = IDLE;
         end
         IDLE: begin
            if (req_valid) state_in = EXEC;
         end
         EXEC: begin
            if (sts.slot_free) state_in = IDLE;
         end
         default: state_in = CLEAR;
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      cmd        = '0;
      case (state_ff)
         CLEAR: begin
            cmd.clear = 1'b1;
         end
         IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         EXEC: begin
            cmd.commit = sts.slot_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

// File: sv/pfla_dp.sv
// Datapath: free ring and page marks memories, ring pointers, pool count,
// clearing counter and the response word register. Depends on pfla_pkg, pfla_ram.
module pfla_dp #(
   parameter int PAGE_NUMBER_BITS = pfla_pkg::PAGE_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  pfla_pkg::ctrl_cmd_type              cmd,
   output pfla_pkg::dp_status_type             sts,
   input  logic                                req_cmd,
   input  logic [pfla_pkg::PAGE_W-1:0]         req_page_number,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [pfla_pkg::PAGE_W-1:0]         rsp_alloc_page,
   output logic [pfla_pkg::STATUS_W-1:0]       rsp_status,
   output logic [pfla_pkg::COUNT_W-1:0]        rsp_free_count
);
   import pfla_pkg::*;

   localparam int PB    = PAGE_NUMBER_BITS;
   localparam int DEPTH = 2 ** PB;

   logic [PB-1:0]       clear_cnt_ff, clear_cnt_in;
   logic [PB-1:0]       head_ff, head_in;
   logic [PB-1:0]       tail_ff, tail_in;
   logic [PB-1:0]       count_ff, count_in;
   logic                cmd_ff;
   logic [PAGE_W-1:0]   page_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [PAGE_W-1:0]   alloc_page_ff, alloc_page_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [COUNT_W-1:0]  free_count_ff, free_count_in;

   logic [PB-1:0]       page_idx;
   logic [PB-1:0]       req_idx;
   logic [MARK_W-1:0]   marks_rd;
   logic [PB-1:0]       ring_rd;
   logic                marks_we;
   logic [PB-1:0]       marks_wa;
   logic [MARK_W-1:0]   marks_wd;
   logic                ring_we;
   logic                is_alloc;
   logic                out_of_range;
   logic                bad_free;
   logic                pool_empty;
   logic                free_ok;
   logic                alloc_ok;

   assign page_idx     = PB'(page_ff);
   assign req_idx      = PB'(req_page_number);
   assign is_alloc     = (cmd_ff == CMD_ALLOC);
   assign out_of_range = (32'(page_ff) >> PB) != 32'd0;
   assign bad_free     = (page_ff == '0) || out_of_range || marks_rd[MARK_FREE_BIT];
   assign pool_empty   = (count_ff == '0);
   assign free_ok      = !is_alloc && !bad_free;
   assign alloc_ok     = is_alloc && !pool_empty;

   assign sts.clear_last = &clear_cnt_ff;
   assign sts.slot_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      marks_we = 1'b0;
      marks_wa = clear_cnt_ff;
      marks_wd = MARK_NONE;
      if (cmd.clear) begin
         marks_we = 1'b1;
      end else if (cmd.commit && free_ok) begin
         marks_we = 1'b1;
         marks_wa = page_idx;
         marks_wd = MARK_POOLED;
      end else if (cmd.commit && alloc_ok) begin
         marks_we = 1'b1;
         marks_wa = ring_rd;
         marks_wd = MARK_ALLOCATED;
      end
   end

   assign ring_we = cmd.commit && free_ok;

   pfla_ram #(.WIDTH(MARK_W), .DEPTH(DEPTH)) u_marks (
      .clock   (clock),
      .wr_en   (marks_we),
      .wr_addr (marks_wa),
      .wr_data (marks_wd),
      .rd_en   (cmd.load),
      .rd_addr (req_idx),
      .rd_data (marks_rd)
   );

   pfla_ram #(.WIDTH(PB), .DEPTH(DEPTH)) u_ring (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (tail_ff),
      .wr_data (page_idx),
      .rd_en   (cmd.load),
      .rd_addr (head_ff),
      .rd_data (ring_rd)
   );

   always_comb begin
      clear_cnt_in  = clear_cnt_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff;
      alloc_page_in = alloc_page_ff;
      status_in     = status_ff;
      free_count_in = free_count_ff;
      if (cmd.clear) begin
         clear_cnt_in = clear_cnt_ff + PB'(1);
      end
      if (free_ok) begin
         tail_in  = tail_ff + PB'(1);
         count_in = count_ff + PB'(1);
      end else if (alloc_ok) begin
         head_in  = head_ff + PB'(1);
         count_in = count_ff - PB'(1);
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.commit) begin
         rsp_valid_in  = 1'b1;
         alloc_page_in = alloc_ok ? PAGE_W'(ring_rd) : '0;
         if (is_alloc) begin
            status_in = pool_empty ? RSP_EMPTY : RSP_OK;
         end else begin
            status_in = bad_free ? RSP_REJECT : RSP_OK;
         end
         free_count_in = COUNT_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_cnt_ff <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clear_cnt_ff <= clear_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.commit) begin
            head_ff  <= head_in;
            tail_ff  <= tail_in;
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff  <= req_cmd;
         page_ff <= req_page_number;
      end
      alloc_page_ff <= alloc_page_in;
      status_ff     <= status_in;
      free_count_ff <= free_count_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_alloc_page = alloc_page_ff;
   assign rsp_status     = status_ff;
   assign rsp_free_count = free_count_ff;

endmodule
